// ===== src/hifo_pkg.sv =====
// shared types and constants of the harmonic ifft overlap-add synthesizer
// used by hifo_cordic, hifo_mac and the top level; depends on nothing
`default_nettype none

package hifo_pkg;

	localparam int OPA_W  = 34;
	localparam int OPB_W  = 18;
	localparam int PROD_W = OPA_W + OPB_W;
	localparam int ACC_W  = 60;
	localparam int TW_W   = 17;

	localparam logic [1:0] CMD_WIN   = 2'd0;
	localparam logic [1:0] CMD_HARM  = 2'd1;
	localparam logic [1:0] CMD_SYNTH = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

	typedef struct packed {
		logic signed [OPA_W-1:0] op_a;
		logic signed [OPB_W-1:0] op_b;
		logic                    accum;
		logic                    negate;
	} mac_ctrl_t;

	// arctangent of 2^-i in 2^32 units per turn
	function automatic logic [29:0] cordic_atan(input logic [3:0] i);
		logic [29:0] r;
		case (i)
			4'd0:    r = 30'd536870912;
			4'd1:    r = 30'd316933406;
			4'd2:    r = 30'd167458907;
			4'd3:    r = 30'd85004756;
			4'd4:    r = 30'd42667331;
			4'd5:    r = 30'd21354465;
			4'd6:    r = 30'd10679838;
			4'd7:    r = 30'd5340245;
			4'd8:    r = 30'd2670163;
			4'd9:    r = 30'd1335087;
			4'd10:   r = 30'd667544;
			4'd11:   r = 30'd333772;
			4'd12:   r = 30'd166886;
			4'd13:   r = 30'd83443;
			4'd14:   r = 30'd41722;
			default: r = 30'd20861;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/hifo_ram.sv =====
// generic single-write, single-read ram with registered read data
// standalone, no package use
`default_nettype none

module hifo_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [$clog2(DEPTH)-1:0]       waddr,
	input  wire logic [WIDTH-1:0]               wdata,
	input  wire logic                           re,
	input  wire logic [$clog2(DEPTH)-1:0]       raddr,
	output logic      [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/hifo_cordic.sv =====
// iterative 16-step cordic giving q1.15 cosine and sine of a 32-bit turn angle
// depends on hifo_pkg (arctangent table, start gain)
`default_nettype none

module hifo_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [31:0]        angle,
	output logic                    done,
	output logic signed [16:0]      cos_val,
	output logic signed [16:0]      sin_val
);

	logic signed [33:0] x_q, y_q, z_q;
	logic [3:0]         it_q;
	logic               run_q, done_q, neg_q;

	logic [31:0]        quad_sum, z0;
	logic               fold;
	logic signed [33:0] dx, dy, at;
	logic signed [33:0] xr, yr, xf, yf;

	always_comb begin
		quad_sum = angle + 32'h4000_0000;
		fold     = quad_sum[31];
		z0       = fold ? angle + 32'h8000_0000 : angle;
		dx       = y_q >>> it_q;
		dy       = x_q >>> it_q;
		at       = $signed({4'b0, hifo_pkg::cordic_atan(it_q)});
		xr       = (x_q + 34'sd16384) >>> 15;
		yr       = (y_q + 34'sd16384) >>> 15;
		xf       = neg_q ? -xr : xr;
		yf       = neg_q ? -yr : yr;
		cos_val  = xf[16:0];
		sin_val  = yf[16:0];
		done     = done_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			it_q   <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q   <= hifo_pkg::CORDIC_X0;
				y_q   <= '0;
				z_q   <= $signed({{2{z0[31]}}, z0});
				neg_q <= fold;
				it_q  <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				if (!z_q[33]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
				it_q <= it_q + 4'd1;
				if (it_q == 4'd15) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	property p_done_after_run;
		@(posedge clk) disable iff (!arst_n) (run_q && it_q == 4'd15 && !start) |=> done_q;
	endproperty
	a_done_after_run: assert property (p_done_after_run) else $error("cordic done missing");

	property p_done_alone;
		@(posedge clk) disable iff (!arst_n) done_q |-> !run_q;
	endproperty
	a_done_alone: assert property (p_done_alone) else $error("cordic done while running");

	property p_no_restart;
		@(posedge clk) disable iff (!arst_n) $rose(run_q) |=> (it_q == 4'd1 || start);
	endproperty
	a_no_restart: assert property (p_no_restart) else $error("cordic step count broken");

endmodule

`default_nettype wire

// ===== src/hifo_mac.sv =====
// shared multiplier with registered product and accumulator
// depends on hifo_pkg (mac_ctrl_t and widths)
`default_nettype none

module hifo_mac (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire hifo_pkg::mac_ctrl_t                   ctrl,
	input  wire logic                                  clear,
	output logic signed [hifo_pkg::PROD_W-1:0]         prod_s1,
	output logic signed [hifo_pkg::ACC_W-1:0]          acc_q
);

	logic                                  accum_s1, neg_s1;
	logic signed [hifo_pkg::ACC_W-1:0]     prod_ext;

	always_comb begin
		prod_ext = $signed({{(hifo_pkg::ACC_W - hifo_pkg::PROD_W){prod_s1[hifo_pkg::PROD_W-1]}},
			prod_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s1  <= '0;
			accum_s1 <= 1'b0;
			neg_s1   <= 1'b0;
			acc_q    <= '0;
		end else begin
			prod_s1  <= $signed(ctrl.op_a) * $signed(ctrl.op_b);
			accum_s1 <= ctrl.accum;
			neg_s1   <= ctrl.negate;
			if (clear) begin
				acc_q <= '0;
			end else if (accum_s1) begin
				acc_q <= neg_s1 ? acc_q - prod_ext : acc_q + prod_ext;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/harmonic_ifft_overlap_add_synth_unit.sv =====
// Harmonic speech synthesizer: inverse fft of a harmonic spectrum, windowed overlap-add into a
// 2*FRAME_LEN sample buffer. After reset the block builds its twiddle table with the cordic
// and takes no word meanwhile. A read word waits for the previous sample word to be taken.
// A synthesize word runs the cordic (16 steps) once per harmonic in range, then for every
// time sample runs four products per distinct bin in use (two for the Nyquist bin) through
// the one shared multiplier.
// depends on hifo_pkg, hifo_ram, hifo_cordic, hifo_mac
`default_nettype none

module harmonic_ifft_overlap_add_synth_unit #(
	parameter int FRAME_LEN     = 80,
	parameter int FFT_SIZE      = 512,
	parameter int MAX_HARMONICS = 80
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic [7:0]         index,
	input  wire logic [15:0]        window_value,
	input  wire logic [15:0]        amplitude,
	input  wire logic [15:0]        phase,
	input  wire logic [15:0]        fundamental,
	input  wire logic [6:0]         harmonic_count,
	input  wire logic               shift_memory,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [23:0]      sample,
	output logic [7:0]              sample_index
);

	localparam int BUF_LEN = 2 * FRAME_LEN;
	localparam int BAW     = $clog2(BUF_LEN);
	localparam int LOG2N   = $clog2(FFT_SIZE);
	localparam int HAW     = $clog2(MAX_HARMONICS);
	localparam int CW      = $clog2(MAX_HARMONICS + 1);
	localparam int PLW     = CW + 16;
	localparam int BFW     = PLW + LOG2N + 1;
	localparam int NW      = LOG2N + 2;
	localparam int LW      = LOG2N + 68;
	localparam int TWW     = 2 * hifo_pkg::TW_W;

	typedef enum logic [4:0] {
		ST_INIT_GO, ST_INIT_WAIT, ST_IDLE, ST_READ,
		ST_H_RD, ST_H_CHK, ST_H_CW, ST_H_MC, ST_H_MS, ST_H_WR,
		ST_S_BEG, ST_E_LRD, ST_E_TWA, ST_E_M1, ST_E_M2, ST_E_M3, ST_E_M4,
		ST_S_FLUSH, ST_S_WIN, ST_S_WR
	} state_t;

	state_t                 state_q;
	logic [LOG2N-1:0]       tw_m_q, bin_q, last_bin_q, m_q;
	logic [CW-1:0]          l_q, cnt_q, list_len_q, j_q;
	logic [15:0]            fund_q, amp_q;
	logic [PLW-1:0]         prod_l_q;
	logic                   shift_q, nyq_q, e_nyq_q;
	logic signed [33:0]     re_q, e_re_q, e_im_q;
	logic signed [16:0]     s1_q, c2_q, s2_q;
	logic [BAW-1:0]         i_q;
	logic                   base_zero_q, base_valid_q, rd_valid_q;
	logic [7:0]             rd_idx_q;
	logic                   out_valid_q;
	logic signed [23:0]     sample_q;
	logic [7:0]             sample_index_q;
	logic [BUF_LEN-1:0]     buf_valid_q;

	// ram ports
	logic                   win_we, win_re, hp_we, hp_re, list_we, list_re;
	logic                   tw_we, tw_re, buf_we, buf_re;
	logic [BAW-1:0]         win_waddr, buf_waddr, buf_raddr;
	logic [15:0]            win_rd;
	logic [HAW-1:0]         hp_waddr, hp_raddr, list_waddr;
	logic [31:0]            hp_rd;
	logic [LW-1:0]          list_wdata, list_rd;
	logic [LOG2N-1:0]       tw_raddr;
	logic [TWW-1:0]         tw_rd;
	logic [31:0]            buf_wdata, buf_rd;

	// shared units
	logic                                   cordic_start, cordic_done;
	logic [31:0]                            cordic_angle;
	logic signed [16:0]                     cos_val, sin_val;
	hifo_pkg::mac_ctrl_t                    mac_ctrl;
	logic                                   mac_clear;
	logic signed [hifo_pkg::PROD_W-1:0]     prod_s1;
	logic signed [hifo_pkg::ACC_W-1:0]      acc_q;

	// datapath helpers
	logic                   acc_in, idx_buf_ok, list_same, bin_ok, last_harm, last_entry;
	logic [BFW-1:0]         bin_full;
	logic [CW-1:0]          l_m1, len_m1;
	logic [NW-1:0]          n_full;
	logic [LOG2N-1:0]       n_val, l_bin, m_neg;
	logic [2*LOG2N-1:0]     bn;
	logic signed [33:0]     l_re, l_im, im_val;
	logic signed [16:0]     tw_c, tw_s;
	logic signed [hifo_pkg::ACC_W-1:0]  ts_full;
	logic signed [hifo_pkg::PROD_W-1:0] wterm;
	logic signed [31:0]     base;
	logic signed [52:0]     wsum;
	logic signed [31:0]     rd_val;
	logic signed [23:0]     rd_sat;

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		acc_in      = in_valid && in_ready;
		idx_buf_ok  = (int'(index) < BUF_LEN);
		bin_full    = ((BFW'(prod_l_q) << LOG2N) + BFW'(32768)) >> 16;
		bin_ok      = (bin_full != '0) && (bin_full <= BFW'(FFT_SIZE / 2));
		l_m1        = l_q - CW'(1);
		len_m1      = list_len_q - CW'(1);
		last_harm   = (l_q == cnt_q);
		last_entry  = (j_q == len_m1);
		list_same   = (list_len_q != '0) && (last_bin_q == bin_q);
		im_val      = nyq_q ? -prod_s1[33:0] : prod_s1[33:0];
		n_full      = NW'(i_q) + NW'(FFT_SIZE - FRAME_LEN + 1);
		n_val       = n_full[LOG2N-1:0];
		l_bin       = list_rd[LW-1 -: LOG2N];
		l_re        = list_rd[67:34];
		l_im        = list_rd[33:0];
		bn          = l_bin * n_val;
		m_neg       = ~m_q + LOG2N'(1);
		tw_c        = tw_rd[TWW-1 -: hifo_pkg::TW_W];
		tw_s        = tw_rd[hifo_pkg::TW_W-1:0];
		ts_full     = (acc_q + 60'sd536870912) >>> 30;
		wterm       = (prod_s1 + 52'sd16384) >>> 15;
		base        = (base_zero_q || !base_valid_q) ? 32'sd0 : $signed(buf_rd);
		wsum        = {{21{base[31]}}, base} + {wterm[51], wterm};
		if (wsum > 53'sd2147483647) begin
			buf_wdata = 32'h7FFF_FFFF;
		end else if (wsum < -53'sd2147483648) begin
			buf_wdata = 32'h8000_0000;
		end else begin
			buf_wdata = wsum[31:0];
		end
		rd_val      = rd_valid_q ? $signed(buf_rd) : 32'sd0;
		if (rd_val > 32'sd8388607) begin
			rd_sat = 24'sh7F_FFFF;
		end else if (rd_val < -32'sd8388608) begin
			rd_sat = 24'sh80_0000;
		end else begin
			rd_sat = rd_val[23:0];
		end
	end

	// ram, cordic and multiplier control
	always_comb begin
		win_we     = acc_in && (cmd == hifo_pkg::CMD_WIN) && idx_buf_ok;
		win_waddr  = BAW'(index);
		win_re     = (state_q == ST_S_BEG);
		hp_we      = acc_in && (cmd == hifo_pkg::CMD_HARM) && (index != 8'd0)
			&& (int'(index) <= MAX_HARMONICS);
		hp_waddr   = HAW'(index - 8'd1);
		hp_re      = (state_q == ST_H_RD);
		hp_raddr   = l_m1[HAW-1:0];
		list_we    = (state_q == ST_H_WR);
		list_waddr = list_same ? len_m1[HAW-1:0] : list_len_q[HAW-1:0];
		list_wdata = {bin_q, re_q, im_val};
		list_re    = (state_q == ST_E_LRD);
		tw_we      = (state_q == ST_INIT_WAIT) && cordic_done;
		tw_re      = (state_q == ST_E_TWA) || (state_q == ST_E_M1);
		tw_raddr   = (state_q == ST_E_TWA) ? bn[LOG2N-1:0] : m_neg;
		buf_we     = (state_q == ST_S_WR);
		buf_waddr  = i_q;
		if (state_q == ST_IDLE) begin
			buf_raddr = BAW'(index);
			buf_re    = acc_in && (cmd == hifo_pkg::CMD_READ) && idx_buf_ok;
		end else begin
			buf_raddr = shift_q ? i_q + BAW'(FRAME_LEN) : i_q;
			buf_re    = (state_q == ST_S_BEG) && !(shift_q && int'(i_q) >= FRAME_LEN - 1);
		end

		cordic_start = (state_q == ST_INIT_GO) || ((state_q == ST_H_CHK) && bin_ok);
		cordic_angle = (state_q == ST_INIT_GO) ? {tw_m_q, {(32 - LOG2N){1'b0}}}
			: {hp_rd[15:0], 16'h0000};

		mac_clear       = (state_q == ST_S_BEG);
		mac_ctrl.op_a   = '0;
		mac_ctrl.op_b   = '0;
		mac_ctrl.accum  = 1'b0;
		mac_ctrl.negate = 1'b0;
		case (state_q)
			ST_H_MC: begin
				mac_ctrl.op_a = $signed({18'b0, amp_q});
				mac_ctrl.op_b = {cos_val[16], cos_val};
			end
			ST_H_MS: begin
				mac_ctrl.op_a = $signed({18'b0, amp_q});
				mac_ctrl.op_b = {sin_val[16], sin_val};
			end
			ST_E_M1: begin
				mac_ctrl.op_a  = e_re_q;
				mac_ctrl.op_b  = {tw_c[16], tw_c};
				mac_ctrl.accum = 1'b1;
			end
			ST_E_M2: begin
				mac_ctrl.op_a   = e_im_q;
				mac_ctrl.op_b   = {s1_q[16], s1_q};
				mac_ctrl.accum  = 1'b1;
				mac_ctrl.negate = 1'b1;
			end
			ST_E_M3: begin
				mac_ctrl.op_a  = e_re_q;
				mac_ctrl.op_b  = {c2_q[16], c2_q};
				mac_ctrl.accum = 1'b1;
			end
			ST_E_M4: begin
				mac_ctrl.op_a  = e_im_q;
				mac_ctrl.op_b  = {s2_q[16], s2_q};
				mac_ctrl.accum = 1'b1;
			end
			ST_S_WIN: begin
				mac_ctrl.op_a = ts_full[33:0];
				mac_ctrl.op_b = $signed({2'b0, win_rd});
			end
			default: begin
				mac_ctrl.accum = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT_GO;
			tw_m_q         <= '0;
			bin_q          <= '0;
			last_bin_q     <= '0;
			m_q            <= '0;
			l_q            <= '0;
			cnt_q          <= '0;
			list_len_q     <= '0;
			j_q            <= '0;
			fund_q         <= '0;
			amp_q          <= '0;
			prod_l_q       <= '0;
			shift_q        <= 1'b0;
			nyq_q          <= 1'b0;
			e_nyq_q        <= 1'b0;
			re_q           <= '0;
			e_re_q         <= '0;
			e_im_q         <= '0;
			s1_q           <= '0;
			c2_q           <= '0;
			s2_q           <= '0;
			i_q            <= '0;
			base_zero_q    <= 1'b0;
			base_valid_q   <= 1'b0;
			rd_valid_q     <= 1'b0;
			rd_idx_q       <= '0;
			out_valid_q    <= 1'b0;
			sample_q       <= '0;
			sample_index_q <= '0;
			buf_valid_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != ST_READ) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT_GO: begin
					state_q <= ST_INIT_WAIT;
				end
				ST_INIT_WAIT: begin
					if (cordic_done) begin
						if (tw_m_q == LOG2N'(FFT_SIZE - 1)) begin
							state_q <= ST_IDLE;
						end else begin
							tw_m_q  <= tw_m_q + LOG2N'(1);
							state_q <= ST_INIT_GO;
						end
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						case (cmd)
							hifo_pkg::CMD_SYNTH: begin
								fund_q     <= fundamental;
								prod_l_q   <= PLW'(fundamental);
								shift_q    <= shift_memory;
								cnt_q      <= (int'(harmonic_count) > MAX_HARMONICS)
									? CW'(MAX_HARMONICS) : CW'(harmonic_count);
								l_q        <= CW'(1);
								list_len_q <= '0;
								i_q        <= '0;
								state_q    <= (harmonic_count == 7'd0) ? ST_S_BEG : ST_H_RD;
							end
							hifo_pkg::CMD_READ: begin
								if (idx_buf_ok) begin
									rd_idx_q   <= index;
									rd_valid_q <= buf_valid_q[BAW'(index)];
									state_q    <= ST_READ;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_READ: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q    <= 1'b1;
						sample_q       <= rd_sat;
						sample_index_q <= rd_idx_q;
						state_q        <= ST_IDLE;
					end
				end
				ST_H_RD: begin
					state_q <= ST_H_CHK;
				end
				ST_H_CHK: begin
					if (bin_ok) begin
						amp_q   <= hp_rd[31:16];
						bin_q   <= bin_full[LOG2N-1:0];
						nyq_q   <= (bin_full == BFW'(FFT_SIZE / 2));
						state_q <= ST_H_CW;
					end else if (last_harm) begin
						state_q <= ST_S_BEG;
					end else begin
						l_q      <= l_q + CW'(1);
						prod_l_q <= prod_l_q + PLW'(fund_q);
						state_q  <= ST_H_RD;
					end
				end
				ST_H_CW: begin
					if (cordic_done) begin
						state_q <= ST_H_MC;
					end
				end
				ST_H_MC: begin
					state_q <= ST_H_MS;
				end
				ST_H_MS: begin
					re_q    <= prod_s1[33:0];
					state_q <= ST_H_WR;
				end
				ST_H_WR: begin
					if (!list_same) begin
						list_len_q <= list_len_q + CW'(1);
					end
					last_bin_q <= bin_q;
					if (last_harm) begin
						state_q <= ST_S_BEG;
					end else begin
						l_q      <= l_q + CW'(1);
						prod_l_q <= prod_l_q + PLW'(fund_q);
						state_q  <= ST_H_RD;
					end
				end
				ST_S_BEG: begin
					base_zero_q  <= shift_q && (int'(i_q) >= FRAME_LEN - 1);
					base_valid_q <= buf_re ? buf_valid_q[buf_raddr] : 1'b0;
					j_q          <= '0;
					state_q      <= (list_len_q == '0) ? ST_S_FLUSH : ST_E_LRD;
				end
				ST_E_LRD: begin
					state_q <= ST_E_TWA;
				end
				ST_E_TWA: begin
					e_re_q  <= l_re;
					e_im_q  <= l_im;
					e_nyq_q <= (l_bin == LOG2N'(FFT_SIZE / 2));
					m_q     <= bn[LOG2N-1:0];
					state_q <= ST_E_M1;
				end
				ST_E_M1: begin
					s1_q    <= tw_s;
					state_q <= ST_E_M2;
				end
				ST_E_M2: begin
					c2_q <= tw_c;
					s2_q <= tw_s;
					if (!e_nyq_q) begin
						state_q <= ST_E_M3;
					end else if (last_entry) begin
						state_q <= ST_S_FLUSH;
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= ST_E_LRD;
					end
				end
				ST_E_M3: begin
					state_q <= ST_E_M4;
				end
				ST_E_M4: begin
					if (last_entry) begin
						state_q <= ST_S_FLUSH;
					end else begin
						j_q     <= j_q + CW'(1);
						state_q <= ST_E_LRD;
					end
				end
				ST_S_FLUSH: begin
					state_q <= ST_S_WIN;
				end
				ST_S_WIN: begin
					state_q <= ST_S_WR;
				end
				ST_S_WR: begin
					buf_valid_q[i_q] <= 1'b1;
					if (int'(i_q) == BUF_LEN - 1) begin
						state_q <= ST_IDLE;
					end else begin
						i_q     <= i_q + BAW'(1);
						state_q <= ST_S_BEG;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign sample       = sample_q;
	assign sample_index = sample_index_q;

	hifo_ram #(.WIDTH(16), .DEPTH(BUF_LEN)) u_win_ram (
		.clk(clk), .we(win_we), .waddr(win_waddr), .wdata(window_value),
		.re(win_re), .raddr(i_q), .rdata(win_rd)
	);

	hifo_ram #(.WIDTH(32), .DEPTH(MAX_HARMONICS)) u_harm_ram (
		.clk(clk), .we(hp_we), .waddr(hp_waddr), .wdata({amplitude, phase}),
		.re(hp_re), .raddr(hp_raddr), .rdata(hp_rd)
	);

	hifo_ram #(.WIDTH(LW), .DEPTH(MAX_HARMONICS)) u_list_ram (
		.clk(clk), .we(list_we), .waddr(list_waddr), .wdata(list_wdata),
		.re(list_re), .raddr(j_q[HAW-1:0]), .rdata(list_rd)
	);

	hifo_ram #(.WIDTH(TWW), .DEPTH(FFT_SIZE)) u_tw_ram (
		.clk(clk), .we(tw_we), .waddr(tw_m_q), .wdata({cos_val, sin_val}),
		.re(tw_re), .raddr(tw_raddr), .rdata(tw_rd)
	);

	hifo_ram #(.WIDTH(32), .DEPTH(BUF_LEN)) u_buf_ram (
		.clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
		.re(buf_re), .raddr(buf_raddr), .rdata(buf_rd)
	);

	hifo_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cordic_start), .angle(cordic_angle),
		.done(cordic_done), .cos_val(cos_val), .sin_val(sin_val)
	);

	hifo_mac u_mac (
		.clk(clk), .arst_n(arst_n), .ctrl(mac_ctrl), .clear(mac_clear),
		.prod_s1(prod_s1), .acc_q(acc_q)
	);

	property p_list_bound;
		@(posedge clk) disable iff (!arst_n) int'(list_len_q) <= MAX_HARMONICS;
	endproperty
	a_list_bound: assert property (p_list_bound) else $error("harmonic list overflow");

	property p_read_hold;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_READ && out_valid_q && !out_ready)
				|=> (state_q == ST_READ && out_valid_q);
	endproperty
	a_read_hold: assert property (p_read_hold) else $error("pending word overwritten");

	property p_buf_addr;
		@(posedge clk) disable iff (!arst_n) buf_we |-> (int'(buf_waddr) < BUF_LEN);
	endproperty
	a_buf_addr: assert property (p_buf_addr) else $error("buffer write out of range");

	property p_harm_range;
		@(posedge clk) disable iff (!arst_n) (state_q == ST_H_CHK) |-> (l_q != '0 && l_q <= cnt_q);
	endproperty
	a_harm_range: assert property (p_harm_range) else $error("harmonic counter out of range");

endmodule

`default_nettype wire

// ===== test/tb_harmonic_ifft_overlap_add_synth_unit.sv =====
// testbench for harmonic_ifft_overlap_add_synth_unit: directed and random load, synthesize and read words
// checked against a behavioral cordic/ifft/overlap-add predictor held in a scoreboard class
// depends on hifo_pkg and the synthesizer rtl
`timescale 1ns / 100ps

module tb_harmonic_ifft_overlap_add_synth_unit;

	localparam int FRAME = 80;
	localparam int NFFT  = 512;
	localparam int NHARM = 80;
	localparam int NBUF  = 2 * FRAME;

	typedef struct {
		logic [1:0]  cmd;
		logic [7:0]  index;
		logic [15:0] window_value;
		logic [15:0] amplitude;
		logic [15:0] phase;
		logic [15:0] fundamental;
		logic [6:0]  harmonic_count;
		logic        shift_memory;
	} synth_word_t;

	typedef struct {
		logic signed [23:0] sample;
		logic [7:0]         sample_index;
	} sample_word_t;

	class synth_scoreboard;
		int             errors;
		bit [15:0]      win[NBUF];
		bit [15:0]      amp[NHARM];
		bit [15:0]      ph[NHARM];
		longint         obuf[NBUF];
		longint         spec_re[NFFT];
		longint         spec_im[NFFT];
		longint         tw_cos[NFFT];
		longint         tw_sin[NFFT];
		sample_word_t   pending_samples[$];
		longint         atan_tab[16] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
			41722, 20861};

		function new();
			errors = 0;
			foreach (obuf[i]) obuf[i] = 0;
			foreach (tw_cos[m]) rotate(32'(m) << 23, tw_cos[m], tw_sin[m]);
		endfunction

		function void rotate(bit [31:0] ang, output longint c, output longint s);
			bit [31:0] z;
			bit [31:0] t;
			bit        neg;
			int        zi;
			longint    x, y, zz, dx, dy;
			z = ang;
			neg = 0;
			t = z + 32'h4000_0000;
			if (t >= 32'h8000_0000) begin
				z = z + 32'h8000_0000;
				neg = 1;
			end
			zi = int'(z);
			zz = zi;
			x = 652032874;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (zz >= 0) begin
					x -= dx; y += dy; zz -= atan_tab[i];
				end else begin
					x += dx; y -= dy; zz += atan_tab[i];
				end
			end
			x = (x + 16384) >>> 15;
			y = (y + 16384) >>> 15;
			c = neg ? -x : x;
			s = neg ? -y : y;
		endfunction

		function longint sat32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function longint windowed(int n, int w);
			longint acc;
			int     m;
			acc = 0;
			n = n % NFFT;
			for (int k = 0; k < NFFT; k++) begin
				if (spec_re[k] != 0 || spec_im[k] != 0) begin
					m = (k * n) % NFFT;
					acc += spec_re[k] * tw_cos[m] - spec_im[k] * tw_sin[m];
				end
			end
			acc = (acc + (64'sd1 <<< 29)) >>> 30;
			return (acc * longint'(win[w]) + 16384) >>> 15;
		endfunction

		function void synthesize(bit [15:0] fund, bit [6:0] count, bit shift);
			longint b, a, c, s;
			int     cnt;
			if (shift) begin
				for (int i = 0; i < FRAME - 1; i++) obuf[i] = obuf[i + FRAME];
				obuf[FRAME - 1] = 0;
			end
			foreach (spec_re[m]) begin
				spec_re[m] = 0;
				spec_im[m] = 0;
			end
			cnt = (count > NHARM) ? NHARM : count;
			for (int l = 1; l <= cnt; l++) begin
				b = (longint'(l) * longint'(fund) * NFFT + 32768) >>> 16;
				if (b < 1 || b > NFFT / 2) continue;
				a = amp[l - 1];
				rotate({ph[l - 1], 16'h0}, c, s);
				spec_re[b] = a * c;
				spec_im[b] = a * s;
				spec_re[NFFT - b] = a * c;
				spec_im[NFFT - b] = -(a * s);
			end
			for (int i = 0; i < FRAME - 1; i++)
				obuf[i] = sat32(obuf[i] + windowed(NFFT - FRAME + 1 + i, i));
			for (int i = FRAME - 1; i < NBUF; i++)
				obuf[i] = sat32((shift ? 64'sd0 : obuf[i]) + windowed(i - (FRAME - 1), i));
		endfunction

		function void note(synth_word_t w);
			sample_word_t r;
			longint       v;
			case (w.cmd)
				hifo_pkg::CMD_WIN: if (w.index < NBUF) win[w.index] = w.window_value;
				hifo_pkg::CMD_HARM: if (w.index >= 1 && w.index <= NHARM) begin
					amp[w.index - 1] = w.amplitude;
					ph[w.index - 1] = w.phase;
				end
				hifo_pkg::CMD_SYNTH: synthesize(w.fundamental, w.harmonic_count, w.shift_memory);
				default: if (w.index < NBUF) begin
					v = obuf[w.index];
					if (v > 8388607) v = 8388607;
					if (v < -8388608) v = -8388608;
					r.sample = 24'(v);
					r.sample_index = w.index;
					pending_samples.push_back(r);
				end
			endcase
		endfunction

		function void check(logic signed [23:0] smp, logic [7:0] idx);
			sample_word_t e;
			if (pending_samples.size() == 0) begin
				$error("unexpected sample word: sample %0d sample_index %0d", smp, idx);
				errors++;
				return;
			end
			e = pending_samples.pop_front();
			if (smp !== e.sample) begin
				$error("sample: expected %0d actual %0d", e.sample, smp);
				errors++;
			end
			if (idx !== e.sample_index) begin
				$error("sample_index: expected %0d actual %0d", e.sample_index, idx);
				errors++;
			end
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         cmd = hifo_pkg::CMD_WIN;
	logic [7:0]         index = 0;
	logic [15:0]        window_value = 0;
	logic [15:0]        amplitude = 0;
	logic [15:0]        phase = 0;
	logic [15:0]        fundamental = 0;
	logic [6:0]         harmonic_count = 0;
	logic               shift_memory = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [23:0] sample;
	logic [7:0]         sample_index;

	synth_scoreboard sb = new();
	bit              quiet = 0;
	int              stall_left = 0;
	int              big_frames = 0;

	harmonic_ifft_overlap_add_synth_unit u_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.index(index), .window_value(window_value), .amplitude(amplitude), .phase(phase),
		.fundamental(fundamental), .harmonic_count(harmonic_count),
		.shift_memory(shift_memory), .out_valid(out_valid), .out_ready(out_ready),
		.sample(sample), .sample_index(sample_index)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		if (quiet) begin
			out_ready <= 1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 17);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) sb.check(sample, sample_index);
	end

	function automatic synth_word_t rand_word(logic [1:0] c);
		synth_word_t w;
		w.cmd = c;
		w.index = $urandom;
		w.window_value = $urandom;
		w.amplitude = $urandom;
		w.phase = $urandom;
		w.fundamental = $urandom;
		w.harmonic_count = $urandom;
		w.shift_memory = $urandom;
		return w;
	endfunction

	task automatic send_word(synth_word_t w);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			in_valid = 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd = w.cmd;
		index = w.index;
		window_value = w.window_value;
		amplitude = w.amplitude;
		phase = w.phase;
		fundamental = w.fundamental;
		harmonic_count = w.harmonic_count;
		shift_memory = w.shift_memory;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sb.note(w);
	endtask

	task automatic send_cmd(logic [1:0] c, int idx, int val, int ph_val, int fund, int count,
			bit shift);
		synth_word_t w;
		w = rand_word(c);
		w.index = idx;
		w.window_value = val;
		w.amplitude = val;
		w.phase = ph_val;
		w.fundamental = fund;
		w.harmonic_count = count;
		w.shift_memory = shift;
		send_word(w);
	endtask

	task automatic read_some(int n);
		for (int i = 0; i < n; i++)
			send_cmd(hifo_pkg::CMD_READ, $urandom_range(0, NBUF - 1), 0, 0, 0, 0, 0);
	endtask

	initial begin
		synth_word_t w;
		int          pick;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		for (int i = 0; i < NBUF; i++) send_cmd(hifo_pkg::CMD_WIN, i, 32768, 0, 0, 0, 0);
		for (int l = 1; l <= NHARM; l++) send_cmd(hifo_pkg::CMD_HARM, l, 65535, 0, 0, 0, 0);

		// saturating frame, accumulate, then shift
		send_cmd(hifo_pkg::CMD_SYNTH, 0, 0, 0, 200, 80, 0);
		send_cmd(hifo_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_READ, 159, 0, 0, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_SYNTH, 0, 0, 0, 200, 80, 1);
		send_cmd(hifo_pkg::CMD_READ, 78, 0, 0, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_READ, 79, 0, 0, 0, 0, 0);
		// nyquist, bin zero, count saturation, ignored indices
		send_cmd(hifo_pkg::CMD_HARM, 1, 1234, 16'h2000, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_HARM, 0, 999, 999, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_HARM, 81, 999, 999, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_WIN, 160, 0, 0, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_WIN, 255, 0, 0, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_SYNTH, 0, 0, 0, 32768, 1, 1);
		send_cmd(hifo_pkg::CMD_READ, 80, 0, 0, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_SYNTH, 0, 0, 0, 0, 127, 0);
		send_cmd(hifo_pkg::CMD_SYNTH, 0, 0, 0, 65535, 127, 1);
		send_cmd(hifo_pkg::CMD_READ, 160, 0, 0, 0, 0, 0);
		send_cmd(hifo_pkg::CMD_READ, 255, 0, 0, 0, 0, 0);
		read_some(4);
		big_frames = 4;

		for (int n = 0; n < 60; n++) begin
			if (n == 50) quiet = 1;
			if (n == 30) begin
				@(negedge clk);
				in_valid = 0;
				wait (sb.pending_samples.size() == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				w = rand_word(hifo_pkg::CMD_WIN);
				if ($urandom_range(0, 9) != 0) w.index = $urandom_range(0, NBUF - 1);
			end else if (pick < 55) begin
				w = rand_word(hifo_pkg::CMD_HARM);
				if ($urandom_range(0, 9) != 0) w.index = $urandom_range(1, NHARM);
			end else if (pick < 62) begin
				w = rand_word(hifo_pkg::CMD_SYNTH);
				if (big_frames < 6 && $urandom_range(0, 15) == 0) begin
					big_frames++;
				end else begin
					w.harmonic_count = $urandom_range(0, 12);
					if ($urandom_range(0, 3) != 0) w.fundamental = $urandom_range(100, 6000);
				end
			end else begin
				w = rand_word(hifo_pkg::CMD_READ);
				if ($urandom_range(0, 9) != 0) w.index = $urandom_range(0, NBUF - 1);
			end
			send_word(w);
		end
		@(negedge clk);
		in_valid = 0;
		wait (sb.pending_samples.size() == 0);
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#50ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
